// ===== hw/rtl/kmds_pkg.sv =====
package kmds_pkg;

	// Matrix geometry and debounce depth
	localparam int ROWS      = 8;
	localparam int COLS      = 16;
	localparam int HISTORY   = 4;
	localparam int MAX_SLOTS = 6;

	localparam int RowW   = 3;
	localparam int ColW   = 4;
	localparam int RoundW = 2;
	localparam int CntW   = 3;
	localparam int HistD  = 32;
	localparam int HistAW = 5;

	localparam logic [15:0] ColMask = 16'((32'd1 << COLS) - 32'd1);

	// Result kinds
	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	// Reset value of the key limit register
	localparam logic [2:0] MaxKeysRst = 3'd6;

	typedef struct packed {
		logic [2:0]  row_index;
		logic [15:0] column_bits;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] key_pos;
		logic [2:0] key_count;
		logic       report_changed;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_WALK,
		ST_SUM
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic merge;
		logic walk;
		logic sum;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic col_last;
		logic row_last;
	} status_t;

endpackage

// ===== hw/rtl/key_matrix_debounce_scanner.sv =====
// A key in column c is written to the output register at its walk step, after the merge step.
// A new row request is taken only after the last one's accept, merge and 16 column steps, plus
//   the end-of-scan summary on the last row; output stall holds the column walk.
// The single column walk over the debounced row sets the pace, one column per cycle unless stalled.
// Reset (arst_n low): history, debounced rows, lists and counts clear at once; the
//   32-entry history memory uses per-entry valid flags, so no clearing pass is needed.
module key_matrix_debounce_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kmds_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output kmds_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_data
);

	kmds_pkg::cmd_t    cmd;
	kmds_pkg::status_t sts;

	// Register writes are taken at any time
	assign cfg_ready = 1'b1;

	kmds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kmds_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

// ===== hw/rtl/kmds_ctrl.sv =====
module kmds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  kmds_pkg::status_t sts,
	output kmds_pkg::cmd_t    cmd
);

	kmds_pkg::state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmds_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			kmds_pkg::ST_IDLE: begin
				if (in_valid) state_nx = kmds_pkg::ST_MERGE;
			end
			kmds_pkg::ST_MERGE: begin
				state_nx = kmds_pkg::ST_WALK;
			end
			kmds_pkg::ST_WALK: begin
				if (sts.out_free && sts.col_last) begin
					state_nx = sts.row_last ? kmds_pkg::ST_SUM : kmds_pkg::ST_IDLE;
				end
			end
			kmds_pkg::ST_SUM: begin
				if (sts.out_free) state_nx = kmds_pkg::ST_IDLE;
			end
			default: state_nx = kmds_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			kmds_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			kmds_pkg::ST_MERGE: cmd.merge = 1'b1;
			kmds_pkg::ST_WALK:  cmd.walk  = sts.out_free;
			kmds_pkg::ST_SUM:   cmd.sum   = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/kmds_datapath.sv =====
module kmds_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  kmds_pkg::cmd_t      cmd,
	output kmds_pkg::status_t   sts,
	input  kmds_pkg::in_item_t  in_data,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_data,
	output kmds_pkg::out_item_t out_data,
	output logic                out_valid,
	input  logic                out_stall
);

	logic [kmds_pkg::RowW-1:0]   row_q;
	logic [15:0]                 sample_q;
	logic [kmds_pkg::RoundW-1:0] round_q, round_inc, round_nx;
	logic [15:0]                 hist_mem [kmds_pkg::HistD];
	logic [kmds_pkg::HistD-1:0]  hist_vld_q;
	logic [15:0]                 rd_data_q;
	logic                        rd_vld_q;
	logic [15:0]                 deb_q [kmds_pkg::ROWS];
	logic [15:0]                 fresh_q;
	logic [kmds_pkg::ColW-1:0]   col_q;
	logic [kmds_pkg::CntW-1:0]   count_q, sent_cnt_q;
	logic [7:0]                  coll_q [kmds_pkg::MAX_SLOTS];
	logic [7:0]                  sent_q [kmds_pkg::MAX_SLOTS];
	logic [2:0]                  max_keys_q;
	kmds_pkg::out_item_t         out_q;
	logic                        out_valid_q;

	logic [kmds_pkg::HistAW-1:0] rd_addr, wr_addr;
	logic [15:0]                 prev, changed, fresh, higher;
	logic [kmds_pkg::CntW-1:0]   lim, cnt_inc;
	logic                        emit, key_last, differ;
	logic [7:0]                  pos;

	// Scan round steps at row 0 and wraps at the history depth
	assign round_inc = (round_q == kmds_pkg::RoundW'(kmds_pkg::HISTORY - 1)) ?
		'0 : round_q + kmds_pkg::RoundW'(1);
	assign round_nx = (in_data.row_index == '0) ? round_inc : round_q;
	assign rd_addr  = {in_data.row_index, round_nx};
	assign wr_addr  = {row_q, round_q};

	// Debounce merge: take the old sample where it agrees with the new one
	assign prev    = rd_vld_q ? rd_data_q : '0;
	assign changed = prev ^ sample_q;
	assign fresh   = ((deb_q[row_q] & changed) | (prev & ~changed)) & kmds_pkg::ColMask;

	// Key limit clamped to 1..MAX_SLOTS
	always_comb begin
		if (max_keys_q == '0) begin
			lim = kmds_pkg::CntW'(1);
		end else if (max_keys_q > kmds_pkg::CntW'(kmds_pkg::MAX_SLOTS)) begin
			lim = kmds_pkg::CntW'(kmds_pkg::MAX_SLOTS);
		end else begin
			lim = max_keys_q;
		end
	end

	// Column walk: one column per step, last flag looks ahead over higher columns
	assign cnt_inc  = count_q + kmds_pkg::CntW'(1);
	assign emit     = cmd.walk && fresh_q[col_q] && (count_q < lim);
	assign higher   = fresh_q & (16'hFFFE << col_q);
	assign key_last = !sts.row_last && ((cnt_inc >= lim) || (higher == '0));
	assign pos      = 8'({row_q, col_q});

	// List compare against the last reported list
	always_comb begin
		differ = (count_q != sent_cnt_q);
		for (int i = 0; i < kmds_pkg::MAX_SLOTS; i++) begin
			if ((kmds_pkg::CntW'(i) < count_q) && (coll_q[i] != sent_q[i])) differ = 1'b1;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.col_last = (col_q == kmds_pkg::ColW'(kmds_pkg::COLS - 1));
	assign sts.row_last = (row_q == kmds_pkg::RowW'(kmds_pkg::ROWS - 1));

	// Sample history memory
	always_ff @(posedge clk) begin
		if (cmd.merge) hist_mem[wr_addr] <= sample_q;
		if (cmd.accept) rd_data_q <= hist_mem[rd_addr];
	end

	// Item registers and fresh row
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q    <= in_data.row_index;
			sample_q <= in_data.column_bits & kmds_pkg::ColMask;
		end
		if (cmd.merge) fresh_q <= fresh;
	end

	// Control and reset-cleared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q     <= '0;
			hist_vld_q  <= '0;
			rd_vld_q    <= 1'b0;
			col_q       <= '0;
			count_q     <= '0;
			sent_cnt_q  <= '0;
			max_keys_q  <= kmds_pkg::MaxKeysRst;
			out_valid_q <= 1'b0;
			for (int r = 0; r < kmds_pkg::ROWS; r++) deb_q[r] <= '0;
			for (int i = 0; i < kmds_pkg::MAX_SLOTS; i++) begin
				coll_q[i] <= '0;
				sent_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) max_keys_q <= cfg_data;
			if (cmd.accept) begin
				round_q  <= round_nx;
				rd_vld_q <= hist_vld_q[rd_addr];
				if (in_data.row_index == '0) count_q <= '0;
			end
			if (cmd.merge) begin
				deb_q[row_q]        <= fresh;
				hist_vld_q[wr_addr] <= 1'b1;
				col_q               <= '0;
			end
			if (cmd.walk) col_q <= col_q + kmds_pkg::ColW'(1);
			if (emit) begin
				coll_q[count_q] <= pos;
				count_q         <= cnt_inc;
			end
			if (cmd.sum && differ) begin
				sent_cnt_q <= count_q;
				for (int i = 0; i < kmds_pkg::MAX_SLOTS; i++) sent_q[i] <= coll_q[i];
			end
			// Output register
			if (emit || cmd.sum) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.kind           <= kmds_pkg::KIND_KEY;
			out_q.key_pos        <= pos;
			out_q.key_count      <= '0;
			out_q.report_changed <= 1'b0;
			out_q.last           <= key_last;
		end else if (cmd.sum) begin
			out_q.kind           <= kmds_pkg::KIND_SUM;
			out_q.key_pos        <= '0;
			out_q.key_count      <= count_q;
			out_q.report_changed <= differ;
			out_q.last           <= 1'b1;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	// Collected keys never exceed the slot count
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kmds_pkg::CntW'(kmds_pkg::MAX_SLOTS))
		else $error("collected count beyond slots");

	// A key result carries the column that was walked
	a_key_col: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_q.key_pos[3:0] == $past(col_q)) && (out_q.kind == kmds_pkg::KIND_KEY))
		else $error("key position does not match walked column");

	// A changed report becomes the sent list
	a_sent_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sum && differ) |=> (sent_cnt_q == out_q.key_count) && out_q.report_changed)
		else $error("sent list not updated on changed report");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int CycleLimit = 300000;
	localparam int DrainCycles = 40;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	kmds_pkg::in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	kmds_pkg::out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [2:0] cfg_data = '0;

	key_matrix_debounce_scanner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Row samples waiting to be sent, key/summary reports waiting to arrive
	kmds_pkg::in_item_t  row_samples_q[$];
	kmds_pkg::out_item_t awaited_reports[$];

	// Shadow of the scanner state
	logic [2:0]  limit_reg = kmds_pkg::MaxKeysRst;
	int unsigned round_ptr = 0;
	logic [15:0] deb_rows[kmds_pkg::ROWS];
	logic [15:0] raw_hist[kmds_pkg::ROWS * kmds_pkg::HISTORY];
	int unsigned list_len = 0;
	logic [7:0]  key_list[kmds_pkg::MAX_SLOTS];
	int unsigned rep_len = 0;
	logic [7:0]  rep_list[kmds_pkg::MAX_SLOTS];

	// Key patterns held per row by the random scans
	logic [15:0] held_keys[kmds_pkg::ROWS];

	int  errors = 0;
	int  cycles = 0;
	bit  row_taken = 1'b0;
	bit  quiet = 1'b0;
	int  in_gap = 0;
	int  out_gap = 0;

	initial begin
		foreach (deb_rows[i]) deb_rows[i] = '0;
		foreach (raw_hist[i]) raw_hist[i] = '0;
		foreach (key_list[i]) key_list[i] = '0;
		foreach (rep_list[i]) rep_list[i] = '0;
		foreach (held_keys[i]) held_keys[i] = '0;
	end

	// Debounce one row request and queue the key and summary reports it yields
	function automatic void debounce_row(input kmds_pkg::in_item_t req);
		int unsigned r;
		int unsigned lim;
		int unsigned c;
		int unsigned slot;
		logic [15:0] samp, prv, cur, chg, fresh;
		logic [7:0]  pos;
		bit          differ;
		kmds_pkg::out_item_t rep;
		kmds_pkg::out_item_t batch[$];

		r = req.row_index;
		if (r >= kmds_pkg::ROWS) return;
		if (r == 0) begin
			round_ptr = (round_ptr + 1) % kmds_pkg::HISTORY;
			list_len = 0;
		end
		samp = req.column_bits & kmds_pkg::ColMask;
		slot = r * kmds_pkg::HISTORY + round_ptr;
		prv = raw_hist[slot];
		cur = deb_rows[r];
		chg = prv ^ samp;
		fresh = ((cur & chg) | (prv & ~chg)) & kmds_pkg::ColMask;
		deb_rows[r] = fresh;
		raw_hist[slot] = samp;

		// zero acts as one, above the slot count acts as the slot count
		if (limit_reg == 0) lim = 1;
		else if (limit_reg > kmds_pkg::MAX_SLOTS) lim = kmds_pkg::MAX_SLOTS;
		else lim = limit_reg;

		for (c = 0; c < kmds_pkg::COLS; c++) begin
			if (fresh[c] && list_len < lim) begin
				pos = 8'((r << 4) | c);
				key_list[list_len] = pos;
				list_len++;
				rep = '0;
				rep.kind = kmds_pkg::KIND_KEY;
				rep.key_pos = pos;
				batch.push_back(rep);
			end
		end

		if (r == kmds_pkg::ROWS - 1) begin
			differ = (list_len != rep_len);
			for (c = 0; !differ && c < list_len; c++) begin
				if (key_list[c] != rep_list[c]) differ = 1'b1;
			end
			if (differ) begin
				rep_list = key_list;
				rep_len = list_len;
			end
			rep = '0;
			rep.kind = kmds_pkg::KIND_SUM;
			rep.key_count = 3'(list_len);
			rep.report_changed = differ;
			batch.push_back(rep);
		end

		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) awaited_reports.push_back(batch[i]);
	endfunction

	function automatic void check_report(input kmds_pkg::out_item_t got);
		kmds_pkg::out_item_t want;

		if (awaited_reports.size() == 0) begin
			$error("unexpected report kind=%0d key_pos=%0d", got.kind, got.key_pos);
			errors++;
			return;
		end
		want = awaited_reports.pop_front();
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
			errors++;
		end
		if (got.key_pos !== want.key_pos) begin
			$error("key_pos: expected %0d, got %0d", want.key_pos, got.key_pos);
			errors++;
		end
		if (got.key_count !== want.key_count) begin
			$error("key_count: expected %0d, got %0d", want.key_count, got.key_count);
			errors++;
		end
		if (got.report_changed !== want.report_changed) begin
			$error("report_changed: expected %0d, got %0d", want.report_changed,
				got.report_changed);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
	endfunction

	// Monitor: sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) check_report(out_data);
			if (in_valid && !in_stall) begin
				debounce_row(in_data);
				row_taken = 1'b1;
			end
		end
	end

	// Row request driver with random idle bursts
	always @(negedge clk) begin
		if (!in_valid || row_taken) begin
			row_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (arst_n && row_samples_q.size() > 0) begin
				if (!quiet && $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(1, 11) - 1;
					in_valid <= 1'b0;
				end else begin
					in_data <= row_samples_q.pop_front();
					in_valid <= 1'b1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Report stall bursts
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(1, 11) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Run time guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_row(input int unsigned r, input logic [15:0] bits);
		kmds_pkg::in_item_t req;

		req.row_index = 3'(r);
		req.column_bits = bits;
		row_samples_q.push_back(req);
	endtask

	// Everything sent and answered, then let rows without reports finish
	task automatic wait_idle();
		do @(posedge clk);
		while (row_samples_q.size() != 0 || in_valid || awaited_reports.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_max_keys(input logic [2:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		limit_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly full scans over held key patterns with some bounce; the rest stray rows
	task automatic random_scans(input int n_rows);
		int sent;
		int unsigned r;
		logic [15:0] bits;

		sent = 0;
		while (sent < n_rows) begin
			if ($urandom_range(0, 6) != 0) begin
				for (r = 0; r < kmds_pkg::ROWS; r++) begin
					if ($urandom_range(0, 5) == 0) begin
						case ($urandom_range(0, 3))
							0: held_keys[r] = '0;
							1: held_keys[r] = 16'(1) << $urandom_range(0, 15);
							2: held_keys[r] = 16'($urandom & $urandom & $urandom);
							default: held_keys[r] = 16'($urandom);
						endcase
					end
					bits = held_keys[r];
					if ($urandom_range(0, 5) == 0) bits ^= 16'(1) << $urandom_range(0, 15);
					push_row(r, bits);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					push_row($urandom_range(0, kmds_pkg::ROWS - 1), 16'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Summary before any scan start, then a held full row that hits the key limit
		push_row(kmds_pkg::ROWS - 1, 16'h0000);
		repeat (5) begin
			push_row(0, 16'hFFFF);
			push_row(kmds_pkg::ROWS - 1, 16'h8001);
		end
		// same list again, then a stray middle row and a release that stays bounced
		push_row(0, 16'hFFFF);
		push_row(kmds_pkg::ROWS - 1, 16'h8001);
		push_row(3, 16'h0000);
		push_row(0, 16'h0000);
		push_row(kmds_pkg::ROWS - 1, 16'h0000);
		push_row(0, 16'h5A5A);
		push_row(5, 16'hA5A5);
		push_row(kmds_pkg::ROWS - 1, 16'hFFFF);
		wait_idle();

		set_max_keys(3'd0);
		random_scans(30);
		wait_idle();

		set_max_keys(3'd7);
		random_scans(30);
		wait_idle();

		set_max_keys(3'd1);
		random_scans(25);
		wait_idle();

		set_max_keys(3'd3);
		random_scans(20);
		wait_idle();

		set_max_keys(3'd6);
		quiet = 1'b1;
		random_scans(20);
		wait_idle();

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
